// File: rtl/kwsm_pkg.sv
// ----------------------------------------------------------------------------
// kwsm_pkg
// Shared types and codes for the k-way sorted merge: command and response
// payloads, status codes, controller states and default sizes.
// ----------------------------------------------------------------------------
package kwsm_pkg;

    localparam int NUM_LISTS_DEFAULT  = 8;
    localparam int LIST_DEPTH_DEFAULT = 256;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic               kind;
        logic [2:0]         list_index;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] head_value;
        logic [2:0]         source_list;
        logic [1:0]         status;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH,
        S_SCAN,
        S_POP_FIN
    } state_t;

endpackage

// File: rtl/kwsm_ram.sv
// ----------------------------------------------------------------------------
// kwsm_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while the read enable is low.
// ----------------------------------------------------------------------------
module kwsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/k_way_sorted_merge.sv
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// A push reads its list's control word with the command transfer and loads
// its result in S_PUSH; a pop scans all list heads and loads it in S_POP_FIN.
// One item at a time: a new command is taken only back in idle. The head scan
// reads one list per cycle through the control RAM and then the store RAM;
// the result then waits for a free response register.
// Reset: pointers and counts read as zero through per-list valid bits; the
// value store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module k_way_sorted_merge #(
    parameter int NUM_LISTS  = kwsm_pkg::NUM_LISTS_DEFAULT,
    parameter int LIST_DEPTH = kwsm_pkg::LIST_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  kwsm_pkg::cmd_t  cmd,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output kwsm_pkg::rsp_t  rsp
);

    // Widths: list number, pointer, fill count, scan counter, store address.
    localparam int LW  = $clog2(NUM_LISTS);
    localparam int PW  = $clog2(LIST_DEPTH);
    localparam int FW  = $clog2(LIST_DEPTH + 1);
    localparam int SCW = $clog2(NUM_LISTS + 1);
    localparam int AW  = $clog2(NUM_LISTS * LIST_DEPTH);
    // Control word per list: {fill count, write pointer, read pointer}.
    localparam int CW  = FW + 2 * PW;

    // ------------------------------------------------------------------
    // Controller state and operand registers
    // ------------------------------------------------------------------
    kwsm_pkg::state_t state_reg, state_next;

    logic                 op_kind_reg;
    logic [LW-1:0]        op_idx_reg;
    logic                 op_bad_reg;
    logic signed [31:0]   op_value_reg;

    logic                 cmd_acc;
    logic                 out_free;
    logic                 cmd_bad;

    // Scan pipeline: issue control read, then store read, then compare.
    logic [SCW-1:0]       scan_cnt_reg, scan_cnt_next;
    logic                 s1_vld_reg, s1_vld_next;
    logic [LW-1:0]        s1_idx_reg;
    logic                 s2_vld_reg, s2_vld_next;
    logic [LW-1:0]        s2_idx_reg;
    logic [CW-1:0]        s2_ctrl_reg;
    logic                 scan_done;
    logic                 take;

    logic                 found_reg, found_next;
    logic signed [31:0]   best_val_reg;
    logic [LW-1:0]        best_idx_reg;
    logic [CW-1:0]        best_ctrl_reg;

    // Control RAM ports and per-list valid bits (unwritten list reads as zero).
    logic [NUM_LISTS-1:0] ctrl_vld_reg;
    logic                 ctrl_rd_vld_reg;
    logic                 ctrl_re;
    logic [LW-1:0]        ctrl_raddr;
    logic [CW-1:0]        ctrl_rdata;
    logic                 ctrl_we;
    logic [LW-1:0]        ctrl_waddr;
    logic [CW-1:0]        ctrl_wdata;
    logic [CW-1:0]        ctrl_cur;
    logic [PW-1:0]        cur_rp, cur_wp;
    logic [FW-1:0]        cur_cnt;
    logic [PW-1:0]        best_rp, best_wp;
    logic [FW-1:0]        best_cnt;

    // Store RAM ports.
    logic                 store_re;
    logic [AW-1:0]        store_raddr;
    logic [31:0]          store_rdata;
    logic                 store_we;
    logic [AW-1:0]        store_waddr;
    logic [31:0]          store_wdata;

    // Response register.
    logic                 rsp_valid_reg;
    kwsm_pkg::rsp_t       rsp_reg;
    logic                 rsp_load;
    kwsm_pkg::rsp_t       rsp_next;
    logic                 push_full;

    // ------------------------------------------------------------------
    // Handshake: take a command only in idle; the response register lets
    // a new command in while the last result still waits.
    // ------------------------------------------------------------------
    assign cmd_stall = (state_reg != kwsm_pkg::S_IDLE);
    assign cmd_acc   = cmd_valid && !cmd_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cmd_bad   = (32'(cmd.list_index) >= 32'(NUM_LISTS));

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Unpack the control word just read; mask lists never written.
    assign ctrl_cur = ctrl_rd_vld_reg ? ctrl_rdata : '0;
    assign cur_rp   = ctrl_cur[PW-1:0];
    assign cur_wp   = ctrl_cur[2*PW-1:PW];
    assign cur_cnt  = ctrl_cur[CW-1:2*PW];

    assign best_rp  = best_ctrl_reg[PW-1:0];
    assign best_wp  = best_ctrl_reg[2*PW-1:PW];
    assign best_cnt = best_ctrl_reg[CW-1:2*PW];

    assign push_full = op_bad_reg || (cur_cnt == FW'(LIST_DEPTH));

    assign scan_done = (scan_cnt_reg == SCW'(NUM_LISTS)) && !s1_vld_reg && !s2_vld_reg;

    // Smaller head wins; equal heads keep the earlier (lower) list.
    assign take = s2_vld_reg && (!found_reg || ($signed(store_rdata) < best_val_reg));

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kwsm_pkg::S_IDLE:
            begin
                if (cmd_acc)
                begin
                    state_next = (cmd.kind == kwsm_pkg::KIND_PUSH) ?
                                 kwsm_pkg::S_PUSH : kwsm_pkg::S_SCAN;
                end
            end
            kwsm_pkg::S_PUSH:
            begin
                if (out_free)
                begin
                    state_next = kwsm_pkg::S_IDLE;
                end
            end
            kwsm_pkg::S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = kwsm_pkg::S_POP_FIN;
                end
            end
            kwsm_pkg::S_POP_FIN:
            begin
                if (out_free)
                begin
                    state_next = kwsm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kwsm_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath control: memory ports, scan pipeline, result
    // ------------------------------------------------------------------
    always_comb
    begin
        ctrl_re       = 1'b0;
        ctrl_raddr    = scan_cnt_reg[LW-1:0];
        ctrl_we       = 1'b0;
        ctrl_waddr    = op_idx_reg;
        ctrl_wdata    = '0;
        store_we      = 1'b0;
        store_waddr   = AW'(op_idx_reg) * AW'(LIST_DEPTH) + AW'(cur_wp);
        store_wdata   = op_value_reg;
        scan_cnt_next = scan_cnt_reg;
        s1_vld_next   = 1'b0;
        s2_vld_next   = 1'b0;
        found_next    = found_reg;
        rsp_load      = 1'b0;
        rsp_next      = '0;

        // Scan stage: s1 holds a list whose control word is arriving now.
        store_re    = 1'b0;
        store_raddr = AW'(s1_idx_reg) * AW'(LIST_DEPTH) + AW'(cur_rp);

        case (state_reg)
            kwsm_pkg::S_IDLE:
            begin
                // Fetch the target list's control word with the transfer.
                ctrl_re       = cmd_acc;
                ctrl_raddr    = LW'(cmd.list_index);
                scan_cnt_next = '0;
                if (cmd_acc)
                begin
                    found_next = 1'b0;
                end
            end
            kwsm_pkg::S_PUSH:
            begin
                if (out_free)
                begin
                    rsp_load = 1'b1;
                    if (push_full)
                    begin
                        rsp_next.status = kwsm_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        // Append at the tail, advance the write pointer.
                        store_we   = 1'b1;
                        ctrl_we    = 1'b1;
                        ctrl_waddr = op_idx_reg;
                        ctrl_wdata = {cur_cnt + FW'(1),
                                      (cur_wp == PW'(LIST_DEPTH - 1)) ?
                                          PW'(0) : cur_wp + PW'(1),
                                      cur_rp};
                        rsp_next.status = kwsm_pkg::STATUS_OK;
                    end
                end
            end
            kwsm_pkg::S_SCAN:
            begin
                if (scan_cnt_reg != SCW'(NUM_LISTS))
                begin
                    ctrl_re       = 1'b1;
                    ctrl_raddr    = scan_cnt_reg[LW-1:0];
                    s1_vld_next   = 1'b1;
                    scan_cnt_next = scan_cnt_reg + SCW'(1);
                end
                // Read the head only of a non-empty list.
                s2_vld_next = s1_vld_reg && (cur_cnt != FW'(0));
                store_re    = s2_vld_next;
                if (take)
                begin
                    found_next = 1'b1;
                end
            end
            kwsm_pkg::S_POP_FIN:
            begin
                if (out_free)
                begin
                    rsp_load = 1'b1;
                    if (found_reg)
                    begin
                        // Drop the winning head, advance its read pointer.
                        ctrl_we    = 1'b1;
                        ctrl_waddr = best_idx_reg;
                        ctrl_wdata = {best_cnt - FW'(1),
                                      best_wp,
                                      (best_rp == PW'(LIST_DEPTH - 1)) ?
                                          PW'(0) : best_rp + PW'(1)};
                        rsp_next.head_value  = best_val_reg;
                        rsp_next.source_list = 3'(best_idx_reg);
                        rsp_next.status      = kwsm_pkg::STATUS_OK;
                    end
                    else
                    begin
                        rsp_next.status = kwsm_pkg::STATUS_EMPTY;
                    end
                end
            end
            default:
            begin
                rsp_load = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= kwsm_pkg::S_IDLE;
            scan_cnt_reg    <= '0;
            s1_vld_reg      <= 1'b0;
            s2_vld_reg      <= 1'b0;
            found_reg       <= 1'b0;
            ctrl_vld_reg    <= '0;
            ctrl_rd_vld_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            s1_vld_reg   <= s1_vld_next;
            s2_vld_reg   <= s2_vld_next;
            found_reg    <= found_next;
            if (ctrl_we)
            begin
                ctrl_vld_reg[ctrl_waddr] <= 1'b1;
            end
            if (ctrl_re)
            begin
                ctrl_rd_vld_reg <= ctrl_vld_reg[ctrl_raddr];
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            op_kind_reg  <= cmd.kind;
            op_idx_reg   <= LW'(cmd.list_index);
            op_bad_reg   <= cmd_bad;
            op_value_reg <= cmd.value;
        end
        s1_idx_reg  <= scan_cnt_reg[LW-1:0];
        s2_idx_reg  <= s1_idx_reg;
        s2_ctrl_reg <= ctrl_cur;
        if (take)
        begin
            best_val_reg  <= $signed(store_rdata);
            best_idx_reg  <= s2_idx_reg;
            best_ctrl_reg <= s2_ctrl_reg;
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    kwsm_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_LISTS)
    ) u_ctrl_ram (
        .clk   (clk),
        .we    (ctrl_we),
        .waddr (ctrl_waddr),
        .wdata (ctrl_wdata),
        .re    (ctrl_re),
        .raddr (ctrl_raddr),
        .rdata (ctrl_rdata)
    );

    kwsm_ram #(
        .WIDTH (32),
        .DEPTH (NUM_LISTS * LIST_DEPTH)
    ) u_store_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .re    (store_re),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

`ifndef ASSERT_OFF
    // A transfer never coincides with a control write back.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc |-> !ctrl_we)
        else $error("control write during command transfer");

    // The store is written only for a push to a list with room.
    assert property (@(posedge clk) disable iff (!rst_n)
        store_we |-> (state_reg == kwsm_pkg::S_PUSH) && (cur_cnt < FW'(LIST_DEPTH))
                     && !op_bad_reg && (op_kind_reg == kwsm_pkg::KIND_PUSH))
        else $error("store write without room");

    // A loaded result is presented in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |=> rsp_valid_reg)
        else $error("loaded result not presented");

    // A removed head comes from a list that held at least one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_we && (state_reg == kwsm_pkg::S_POP_FIN)) |-> (best_cnt != FW'(0)))
        else $error("pop from empty list");

    // The scan counter stops at the list count.
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_cnt_reg <= SCW'(NUM_LISTS))
        else $error("scan counter overrun");
`endif

endmodule
